// ----- sv/ght_pkg.sv -----
// ----------------------------------------------------------------------------
// Generational handle table package
// Request codes, status codes and handle layout shared by the table's modules.
// ----------------------------------------------------------------------------
package ght_pkg;

  // Handle layout: generation above the low byte, slot number plus one below.
  localparam int unsigned HandleW = 64;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned HGenW   = HandleW - IdxW;
  localparam int unsigned NewHW   = 63;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned SlotOutW = 5;

  // Request codes. The fourth code is undefined and answered as invalid.
  localparam logic [ReqW-1:0] REQ_INSTALL = 2'd0;
  localparam logic [ReqW-1:0] REQ_LOOKUP  = 2'd1;
  localparam logic [ReqW-1:0] REQ_CLOSE   = 2'd2;
  localparam logic [ReqW-1:0] REQ_RSVD    = 2'd3;

  // Status codes.
  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_INVALID   = 3'd1;
  localparam logic [StatusW-1:0] ST_EXHAUSTED = 3'd2;
  localparam logic [StatusW-1:0] ST_UNKNOWN   = 3'd3;
  localparam logic [StatusW-1:0] ST_CLEANUP   = 3'd4;

  // Update commands for the slot table.
  typedef struct packed {
    logic install;     // set occupied, write new generation
    logic free;        // clear occupied
    logic mark_stuck;  // set stuck until reset
  } tbl_op_t;

endpackage

// ----- sv/ght_ffs.sv -----
// ----------------------------------------------------------------------------
// Lowest free slot finder
// Priority encoder that returns the lowest slot that is available.
// ----------------------------------------------------------------------------
module ght_ffs #(
  parameter int unsigned NUM_SLOTS = 32,
  parameter int unsigned SLOT_W    = 5
) (
  input  logic [NUM_SLOTS-1:0] avail_i,
  output logic                 found_o,
  output logic [SLOT_W-1:0]    slot_o
);

  assign found_o = |avail_i;

  // Scan from the top so the lowest available slot wins.
  always_comb begin
    slot_o = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (avail_i[i]) begin
        slot_o = SLOT_W'(i);
      end
    end
  end

endmodule

// ----- sv/ght_decode.sv -----
// ----------------------------------------------------------------------------
// Handle decoder
// Splits a handle into slot and generation and checks that it can name a slot.
// ----------------------------------------------------------------------------
module ght_decode #(
  parameter int unsigned NUM_SLOTS = 32,
  parameter int unsigned SLOT_W    = 5
) (
  input  logic [ght_pkg::HandleW-1:0] handle_i,
  output logic                        valid_o,
  output logic [SLOT_W-1:0]           slot_o,
  output logic [ght_pkg::HGenW-1:0]   gen_o
);

  localparam logic [ght_pkg::IdxW-1:0] MaxIdx = ght_pkg::IdxW'(NUM_SLOTS);

  logic [ght_pkg::IdxW-1:0] idx;
  logic [ght_pkg::IdxW-1:0] idx_m1;

  assign idx    = handle_i[ght_pkg::IdxW-1:0];
  assign gen_o  = handle_i[ght_pkg::HandleW-1:ght_pkg::IdxW];
  assign idx_m1 = idx - 1'b1;
  assign slot_o = idx_m1[SLOT_W-1:0];

  // A zero generation part already covers the all-zero handle.
  assign valid_o = (idx != '0) && (idx <= MaxIdx) && (gen_o != '0);

endmodule

// ----- sv/ght_table.sv -----
// ----------------------------------------------------------------------------
// Slot table
// Occupied, stuck and generation state of every slot, with one read port.
// ----------------------------------------------------------------------------
module ght_table #(
  parameter int unsigned NUM_SLOTS = 32,
  parameter int unsigned GEN_BITS  = 55,
  parameter int unsigned SLOT_W    = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ght_pkg::tbl_op_t     op_i,
  input  logic [SLOT_W-1:0]    wr_slot_i,
  input  logic [GEN_BITS-1:0]  wr_gen_i,
  input  logic [SLOT_W-1:0]    rd_slot_i,
  output logic [GEN_BITS-1:0]  rd_gen_o,
  output logic [NUM_SLOTS-1:0] occupied_o,
  output logic [NUM_SLOTS-1:0] stuck_o
);

  logic [NUM_SLOTS-1:0] occupied_q;
  logic [NUM_SLOTS-1:0] stuck_q;
  logic [GEN_BITS-1:0]  gen_q [NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occupied_q <= '0;
      stuck_q    <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        gen_q[i] <= '0;
      end
    end else begin
      if (op_i.install) begin
        occupied_q[wr_slot_i] <= 1'b1;
        gen_q[wr_slot_i]      <= wr_gen_i;
      end
      if (op_i.free) begin
        occupied_q[wr_slot_i] <= 1'b0;
      end
      if (op_i.mark_stuck) begin
        stuck_q[wr_slot_i] <= 1'b1;
      end
    end
  end

  assign rd_gen_o   = gen_q[rd_slot_i];
  assign occupied_o = occupied_q;
  assign stuck_o    = stuck_q;

endmodule

// ----- sv/generational_handle_table.sv -----
// ----------------------------------------------------------------------------
// Generational handle table
// Issues, checks and retires generation-tagged handles for a table of slots.
// ----------------------------------------------------------------------------
// A request is captured in the request register, then its result in the result
// register, which drives the result ports with done_o high.
// Throughput: one request per cycle; busy stays low and a request may
// follow in every cycle, since each result is ready one register stage later.
// Reset clears every slot to free, not stuck, generation zero; done_o is low.
// ----------------------------------------------------------------------------
module generational_handle_table #(
  parameter int unsigned NUM_SLOTS = 32,
  parameter int unsigned GEN_BITS  = 55
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [ght_pkg::ReqW-1:0]        req_type_i,
  input  logic [ght_pkg::HandleW-1:0]     handle_i,
  input  logic                            payload_empty_i,
  input  logic                            external_ok_i,
  output logic                            done_o,
  output logic [ght_pkg::StatusW-1:0]     status_o,
  output logic [ght_pkg::NewHW-1:0]       new_handle_o,
  output logic [ght_pkg::SlotOutW-1:0]    slot_index_o
);

  // Slot numbers need at least one bit even for a single-slot table.
  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // The whole request is decided by one short stretch of logic between the
  // request register and the result register, so nothing ever holds the
  // requester off.
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Request register
  // --------------------------------------------------------------------------
  logic                          valid_q;
  logic [ght_pkg::ReqW-1:0]      req_q;
  logic [ght_pkg::HandleW-1:0]   handle_q;
  logic                          empty_q;
  logic                          ext_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q    <= req_type_i;
      handle_q <= handle_i;
      empty_q  <= payload_empty_i;
      ext_ok_q <= external_ok_i;
    end
  end

  // --------------------------------------------------------------------------
  // Slot state, free slot search and handle decode
  // --------------------------------------------------------------------------
  ght_pkg::tbl_op_t             tbl_op;
  logic [SlotW-1:0]             wr_slot;
  logic [GEN_BITS-1:0]          next_gen;
  logic [SlotW-1:0]             rd_slot;
  logic [GEN_BITS-1:0]          rd_gen;
  logic [NUM_SLOTS-1:0]         occupied;
  logic [NUM_SLOTS-1:0]         stuck;
  logic                         free_found;
  logic [SlotW-1:0]             free_slot;
  logic                         dec_valid;
  logic [SlotW-1:0]             dec_slot;
  logic [ght_pkg::HGenW-1:0]    dec_gen;

  ght_table #(
    .NUM_SLOTS (NUM_SLOTS),
    .GEN_BITS  (GEN_BITS),
    .SLOT_W    (SlotW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (tbl_op),
    .wr_slot_i  (wr_slot),
    .wr_gen_i   (next_gen),
    .rd_slot_i  (rd_slot),
    .rd_gen_o   (rd_gen),
    .occupied_o (occupied),
    .stuck_o    (stuck)
  );

  // A stuck slot is never handed out again until reset.
  ght_ffs #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SlotW)
  ) u_ffs (
    .avail_i (~occupied & ~stuck),
    .found_o (free_found),
    .slot_o  (free_slot)
  );

  ght_decode #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SlotW)
  ) u_decode (
    .handle_i (handle_q),
    .valid_o  (dec_valid),
    .slot_o   (dec_slot),
    .gen_o    (dec_gen)
  );

  // Install reads the slot it is about to fill; lookup and close read the
  // slot named by the handle. Only one of them is live per request.
  assign rd_slot = (req_q == ght_pkg::REQ_INSTALL) ? free_slot : dec_slot;

  // The generation counts up and wraps from its largest value back to one,
  // so a handle never carries generation zero.
  assign next_gen = (rd_gen == '1) ? GEN_BITS'(1) : rd_gen + 1'b1;

  // --------------------------------------------------------------------------
  // Request evaluation
  // --------------------------------------------------------------------------
  logic [ght_pkg::StatusW-1:0]  status_d;
  logic [ght_pkg::NewHW-1:0]    new_handle_d;
  logic [SlotW-1:0]             slot_d;
  logic [ght_pkg::HandleW-1:0]  handle_full;
  logic                         gen_match;

  assign handle_full = (ght_pkg::HandleW'(next_gen) << ght_pkg::IdxW) |
                       (ght_pkg::HandleW'(free_slot) + ght_pkg::HandleW'(1));
  assign gen_match   = (dec_gen == ght_pkg::HGenW'(rd_gen));

  always_comb begin
    status_d     = ght_pkg::ST_INVALID;
    new_handle_d = '0;
    slot_d       = '0;
    wr_slot      = dec_slot;
    tbl_op       = '0;
    case (req_q) inside
      ght_pkg::REQ_INSTALL: begin
        wr_slot = free_slot;
        // An empty payload is turned away before any slot is looked at.
        if (!empty_q) begin
          if (!free_found) begin
            status_d = ght_pkg::ST_EXHAUSTED;
          end else if (!ext_ok_q) begin
            // Transfer failed: the chosen slot is reported but left alone.
            slot_d = free_slot;
          end else begin
            slot_d         = free_slot;
            status_d       = ght_pkg::ST_OK;
            new_handle_d   = handle_full[ght_pkg::NewHW-1:0];
            tbl_op.install = valid_q;
          end
        end
      end
      ght_pkg::REQ_LOOKUP, ght_pkg::REQ_CLOSE: begin
        if (dec_valid) begin
          slot_d = dec_slot;
          if (!occupied[dec_slot] || !gen_match) begin
            status_d = ght_pkg::ST_UNKNOWN;
          end else if (req_q == ght_pkg::REQ_LOOKUP) begin
            status_d = ext_ok_q ? ght_pkg::ST_OK : ght_pkg::ST_INVALID;
          end else begin
            // Close always frees the slot; a failed cleanup also parks it.
            tbl_op.free = valid_q;
            if (ext_ok_q) begin
              status_d = ght_pkg::ST_OK;
            end else begin
              tbl_op.mark_stuck = valid_q;
              status_d          = ght_pkg::ST_CLEANUP;
            end
          end
        end
      end
      default: begin
        status_d = ght_pkg::ST_INVALID;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic                          done_q;
  logic [ght_pkg::StatusW-1:0]   status_q;
  logic [ght_pkg::NewHW-1:0]     new_handle_q;
  logic [ght_pkg::SlotOutW-1:0]  slot_index_q;
  logic [ght_pkg::IdxW-1:0]      slot_wide;

  // The slot port is five bits wide; larger tables report the low bits.
  assign slot_wide = ght_pkg::IdxW'(slot_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      status_q     <= status_d;
      new_handle_q <= new_handle_d;
      slot_index_q <= slot_wide[ght_pkg::SlotOutW-1:0];
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign new_handle_o = new_handle_q;
  assign slot_index_o = slot_index_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Every request in the request register yields exactly one result strobe.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q == done_q |=> done_o == $past(valid_q))
    else $error("result strobe does not follow the request register");

  // A slot is never both occupied and stuck.
  a_occ_stuck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occupied & stuck) == '0)
    else $error("slot is occupied and stuck at once");

  // Once stuck, a slot stays stuck until reset.
  a_stuck_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (($past(stuck) & ~stuck) == '0))
    else $error("stuck slot was released without reset");

  // A handle is only issued with a success status.
  a_handle_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (new_handle_o != '0) |-> status_o == ght_pkg::ST_OK)
    else $error("handle issued on a failed request");

endmodule
